// ===== sv/rf3_pkg.sv =====
package rf3_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 16;
  localparam int FILT_W         = 21;
  localparam int LEN_W          = 11;
  localparam int MAX_ROW_LENGTH = 1024;
  localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int FRAC_BITS      = 12;

  localparam int MIN_ROW_LENGTH = 2;
  localparam int ROW_LENGTH_RST = 5;
  localparam logic signed [COEF_W-1:0] COEF_LEFT_RST   = -16'sd4096;
  localparam logic signed [COEF_W-1:0] COEF_CENTRE_RST = 16'sd0;
  localparam logic signed [COEF_W-1:0] COEF_RIGHT_RST  = 16'sd4096;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_LEFT   = 2'd0,
    REG_COEF_CENTRE = 2'd1,
    REG_COEF_RIGHT  = 2'd2,
    REG_ROW_LENGTH  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] left;
    logic signed [COEF_W-1:0] centre;
    logic signed [COEF_W-1:0] right;
  } coef_t;

  // operands of one output word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] right;
    logic                       row_end;
  } job_t;

endpackage

// ===== sv/rf3_in_if.sv =====
interface rf3_in_if;
  import rf3_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/rf3_out_if.sv =====
interface rf3_out_if;
  import rf3_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [FILT_W-1:0] filtered;
  logic                     row_end;

  modport source (output valid, output filtered, output row_end, input ready);
  modport sink   (input valid, input filtered, input row_end, output ready);
endinterface

// ===== sv/rf3_mac.sv =====
module rf3_mac (
  input  logic          clk,
  input  logic          rst_n,
  input  rf3_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  input  rf3_pkg::coef_t coef,
  rf3_out_if.source     out_ch
);
  import rf3_pkg::*;

  logic                     p_valid_r;
  logic signed [PROD_W-1:0] p_left_r;
  logic signed [PROD_W-1:0] p_centre_r;
  logic signed [PROD_W-1:0] p_right_r;
  logic                     p_row_end_r;
  logic                     out_valid_r;
  logic signed [FILT_W-1:0] filtered_r;
  logic                     row_end_r;
  logic                     o_ready;
  logic                     p_ready;
  logic                     job_fire;
  logic                     p_fire;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_shr;

  // stall chain: a stage takes a word when it is empty or draining
  assign o_ready   = !out_valid_r || out_ch.ready;
  assign p_ready   = !p_valid_r || o_ready;
  assign job_ready = p_ready;
  assign job_fire  = job_valid && p_ready;
  assign p_fire    = p_valid_r && o_ready;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_ready) begin
      p_valid_r <= job_valid;
    end
    if (job_fire) begin
      p_left_r    <= PROD_W'(job.left) * PROD_W'(coef.left);
      p_centre_r  <= PROD_W'(job.centre) * PROD_W'(coef.centre);
      p_right_r   <= PROD_W'(job.right) * PROD_W'(coef.right);
      p_row_end_r <= job.row_end;
    end
  end

  // sum and floor shift
  assign sum     = SUM_W'(p_left_r) + SUM_W'(p_centre_r) + SUM_W'(p_right_r);
  assign sum_shr = sum >>> FRAC_BITS;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= p_valid_r;
    end
    if (p_fire) begin
      filtered_r <= sum_shr[FILT_W-1:0];
      row_end_r  <= p_row_end_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = filtered_r;
  assign out_ch.row_end  = row_end_r;

  a_job_to_prod: assert property (@(posedge clk) disable iff (!rst_n)
    job_fire |=> p_valid_r)
    else $error("accepted job did not reach product stage");
  a_prod_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    p_fire |=> out_valid_r && row_end_r == $past(p_row_end_r))
    else $error("product word lost on the way to output");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !p_valid_r && !out_valid_r |-> job_ready)
    else $error("empty pipeline refuses a job");
endmodule

// ===== sv/row_fir3_reflect_border.sv =====
// Horizontal three-tap filter with reflect-101 row borders.
// in_ch carries one signed 16-bit sample per word in row order; out_ch
// carries filtered = floor((cl*x[c-1] + cc*x[c] + cr*x[c+1]) / 4096) and
// row_end, high on the result of a row's last column. Both use valid/ready;
// a word moves on a rising edge with valid and ready high.
// cfg_we/cfg_index/cfg_data write coef_left (0), coef_centre (1),
// coef_right (2) and row_length (3); write only while the block is idle.
// The first sample of a row yields no word, each later sample yields the
// word of the previous column, and the last sample yields two words.
// Throughput: one sample per cycle while out_ch does not stall; at each
// row end input ready drops while the second word waits in the hold slot.
// A word passes the job register, the product register and the output
// register after the sample that completes it is accepted; the second
// word of a row end waits in the hold slot and follows the first.
// Reset (synchronous, rst_n low) restores the default coefficients, row
// length 5, clears the stored samples and column, and empties the pipeline.
// When out_ch stalls, the pipeline fills and in_ch.ready drops; nothing is
// lost or repeated.
module row_fir3_reflect_border (
  input  logic                           clk,
  input  logic                           rst_n,
  rf3_in_if.sink                         in_ch,
  rf3_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rf3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rf3_pkg::*;

  coef_t                      coef_r;
  logic [COL_W-1:0]           len_m1_r;
  logic [COL_W-1:0]           col_r;
  logic signed [SAMPLE_W-1:0] older_r;
  logic signed [SAMPLE_W-1:0] newer_r;
  job_t                       job_r;
  logic                       j_valid_r;
  job_t                       pend_r;
  logic                       pend_valid_r;

  logic                       mac_ready;
  logic                       j_ready;
  logic                       in_fire;
  logic                       first;
  logic                       last;
  logic signed [SAMPLE_W-1:0] x;
  job_t                       job1;
  job_t                       job2;
  logic [LEN_W-1:0]           len_wr;

  // configuration writes; keep row length as last column index
  assign len_wr = cfg_data[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.left   <= COEF_LEFT_RST;
      coef_r.centre <= COEF_CENTRE_RST;
      coef_r.right  <= COEF_RIGHT_RST;
      len_m1_r      <= COL_W'(ROW_LENGTH_RST - 1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_LEFT:   coef_r.left   <= cfg_data[COEF_W-1:0];
        REG_COEF_CENTRE: coef_r.centre <= cfg_data[COEF_W-1:0];
        REG_COEF_RIGHT:  coef_r.right  <= cfg_data[COEF_W-1:0];
        REG_ROW_LENGTH: begin
          if (len_wr < LEN_W'(MIN_ROW_LENGTH)) begin
            len_m1_r <= COL_W'(MIN_ROW_LENGTH - 1);
          end else if (len_wr > LEN_W'(MAX_ROW_LENGTH)) begin
            len_m1_r <= COL_W'(MAX_ROW_LENGTH - 1);
          end else begin
            len_m1_r <= COL_W'(len_wr - LEN_W'(1));
          end
        end
        default: ;
      endcase
    end
  end

  // handshake and border decisions
  assign x        = in_ch.sample;
  assign j_ready  = !j_valid_r || mac_ready;
  assign in_ch.ready = !pend_valid_r && j_ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign first    = (col_r == '0);
  assign last     = (col_r >= len_m1_r);

  // previous column; at column 1 mirror the right neighbour to the left
  always_comb begin
    job1.left    = (col_r == COL_W'(1)) ? x : older_r;
    job1.centre  = newer_r;
    job1.right   = x;
    job1.row_end = 1'b0;
    job2.left    = newer_r;
    job2.centre  = x;
    job2.right   = newer_r;
    job2.row_end = 1'b1;
  end

  // advance sample history and column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      older_r <= '0;
      newer_r <= '0;
    end else if (in_fire) begin
      older_r <= newer_r;
      newer_r <= x;
      if (first) begin
        col_r <= COL_W'(1);
      end else if (last) begin
        col_r <= '0;
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // job register, with a hold slot for the row-end word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r    <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (pend_valid_r) begin
      if (j_ready) begin
        j_valid_r    <= 1'b1;
        job_r        <= pend_r;
        pend_valid_r <= 1'b0;
      end
    end else if (in_fire && !first) begin
      j_valid_r <= 1'b1;
      job_r     <= job1;
      if (last) begin
        pend_valid_r <= 1'b1;
        pend_r       <= job2;
      end
    end else if (j_ready) begin
      j_valid_r <= 1'b0;
    end
  end

  rf3_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_r),
    .job_valid (j_valid_r),
    .job_ready (mac_ready),
    .coef      (coef_r),
    .out_ch    (out_ch)
  );

  a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !in_ch.ready)
    else $error("input taken while row-end word pending");
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !first && last |=> pend_valid_r && pend_r.row_end && col_r == '0)
    else $error("row end not handled");
  a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && j_ready |=> j_valid_r && job_r.row_end && !pend_valid_r)
    else $error("pending row-end word not forwarded");
endmodule

// ===== tb/rf3_checker.sv =====
`timescale 1ns / 1ps

// Watch both channels and the register port, predict every filtered word
// and compare it with what leaves the block.
module rf3_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  rf3_in_if                              in_mon,
  rf3_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [rf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rf3_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             open_count
);
  import rf3_pkg::*;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     row_end;
  } filt_word_t;

  filt_word_t                 expected_words[$];
  coef_t                      coefs;
  logic [LEN_W-1:0]           row_len;
  logic signed [SAMPLE_W-1:0] prev2_sample;
  logic signed [SAMPLE_W-1:0] prev1_sample;
  int                         column;
  int                         mismatches;

  // Weighted sum of three taps, floor-divided by 4096
  function automatic logic signed [FILT_W-1:0] floor_taps(
    input logic signed [SAMPLE_W-1:0] l,
    input logic signed [SAMPLE_W-1:0] c,
    input logic signed [SAMPLE_W-1:0] r
  );
    longint acc;
    acc = longint'($signed(coefs.left)) * longint'(l)
        + longint'($signed(coefs.centre)) * longint'(c)
        + longint'($signed(coefs.right)) * longint'(r);
    return FILT_W'(acc >>> FRAC_BITS);
  endfunction

  // Advance the row state by one sample and queue the words it completes
  function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] x);
    int                         eff_len;
    logic signed [SAMPLE_W-1:0] left;
    eff_len = int'(row_len);
    if (eff_len < MIN_ROW_LENGTH) eff_len = MIN_ROW_LENGTH;
    if (eff_len > MAX_ROW_LENGTH) eff_len = MAX_ROW_LENGTH;
    if (column == 0) begin
      column = 1;
    end else begin
      // mirror the inner neighbour at the row start
      left = (column == 1) ? x : prev2_sample;
      expected_words.push_back('{floor_taps(left, prev1_sample, x), 1'b0});
      if (column >= eff_len - 1) begin
        // mirror at the row end and flush the last column
        expected_words.push_back('{floor_taps(prev1_sample, x, prev1_sample), 1'b1});
        column = 0;
      end else begin
        column = column + 1;
      end
    end
    prev2_sample = prev1_sample;
    prev1_sample = x;
  endfunction

  always @(posedge clk) begin
    filt_word_t exp_word;
    if (!rst_n) begin
      coefs.left   = COEF_LEFT_RST;
      coefs.centre = COEF_CENTRE_RST;
      coefs.right  = COEF_RIGHT_RST;
      row_len      = LEN_W'(ROW_LENGTH_RST);
      prev2_sample = '0;
      prev1_sample = '0;
      column       = 0;
      mismatches   = 0;
      expected_words.delete();
    end else begin
      // track register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COEF_LEFT: begin
            coefs.left = cfg_data;
          end
          REG_COEF_CENTRE: begin
            coefs.centre = cfg_data;
          end
          REG_COEF_RIGHT: begin
            coefs.right = cfg_data;
          end
          REG_ROW_LENGTH: begin
            row_len = cfg_data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // compare an outgoing word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected word filtered=%0d row_end=%0b", $realtime,
                     out_mon.filtered, out_mon.row_end);
          end
          mismatches = mismatches + 1;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_mon.filtered !== exp_word.filtered ||
              out_mon.row_end !== exp_word.row_end) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch filtered exp %0d got %0d, row_end exp %0b got %0b",
                       $realtime, exp_word.filtered, out_mon.filtered,
                       exp_word.row_end, out_mon.row_end);
            end
            mismatches = mismatches + 1;
          end
        end
      end

      // predict from an accepted sample
      if (in_mon.valid && in_mon.ready) begin
        predict_sample(in_mon.sample);
      end
    end
    fail_count <= mismatches;
    open_count <= expected_words.size();
  end

endmodule

// ===== tb/tb_row_fir3_reflect_border.sv =====
`timescale 1ns / 1ps

module tb_row_fir3_reflect_border;
  import rf3_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    open_count;
  int                    samples_sent;
  bit                    in_burst;
  bit                    out_burst;

  rf3_in_if  in_ch ();
  rf3_out_if out_ch ();

  row_fir3_reflect_border u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rf3_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("row_fir3_reflect_border test failed");
    $finish;
  end

  // Mostly random samples, with the extremes weighted up
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Coefficients: extremes, unity taps or random Q4.12
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'h1000;
      4:       return 16'hf000;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent = samples_sent + 1;
  endtask

  // Drop valid and wait until every predicted word has left the block
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers back to back
  task automatic write_settings(
    input logic [COEF_W-1:0]     cl,
    input logic [COEF_W-1:0]     cc,
    input logic [COEF_W-1:0]     cr,
    input logic [CFG_DATA_W-1:0] len_word
  );
    cfg_we    <= 1'b1;
    cfg_index <= REG_COEF_LEFT;
    cfg_data  <= cl;
    @(posedge clk);
    cfg_index <= REG_COEF_CENTRE;
    cfg_data  <= cc;
    @(posedge clk);
    cfg_index <= REG_COEF_RIGHT;
    cfg_data  <= cr;
    @(posedge clk);
    cfg_index <= REG_ROW_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Output side: random stall before taking each word
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int               n_items;
    int               eff_len;
    int               phase;
    int               wait_cycles;
    logic [LEN_W-1:0] len;
    logic [4:0]       len_hi;

    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_COEF_LEFT;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    samples_sent = 0;
    in_burst     = 1'b0;
    out_burst    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, row of five: two full rows, the first of extremes, then stop mid-row
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    send_sample(-16'sd1);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(16'sd7);

    // Shortest row, shortened mid-row; most negative weights
    settle();
    write_settings(16'h8000, 16'h8000, 16'h8000, 16'd2);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);

    // Row length below the minimum; most positive weights
    settle();
    write_settings(16'h7fff, 16'h7fff, 16'h7fff, 16'd1);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);

    // Random phases: mostly short rows, a few at or past the longest
    phase = 0;
    while (samples_sent < 1850) begin
      settle();
      case ((phase == 0) ? 0 : $urandom_range(1, 20))
        0:       len = 11'd2047;
        1:       len = LEN_W'($urandom_range(0, 1));
        2:       len = LEN_W'($urandom_range(1024, 2047));
        default: len = LEN_W'($urandom_range(2, 12));
      endcase
      eff_len = int'(len);
      if (eff_len < MIN_ROW_LENGTH) eff_len = MIN_ROW_LENGTH;
      if (eff_len > MAX_ROW_LENGTH) eff_len = MAX_ROW_LENGTH;
      len_hi = 5'($urandom());
      write_settings(pick_coef(), pick_coef(), pick_coef(), {len_hi, len});
      n_items = (eff_len > 64) ? eff_len + $urandom_range(0, 3)
                               : $urandom_range(1, 6 * eff_len);
      // stop at the planned total
      if (n_items > 1850 - samples_sent) n_items = 1850 - samples_sent;
      repeat (n_items) send_sample(pick_sample());
      phase = phase + 1;
    end

    // Drain with a bound, then give the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (open_count != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles = wait_cycles + 1;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("row_fir3_reflect_border test passed");
    end else begin
      $display("row_fir3_reflect_border test failed");
    end
    $finish;
  end

endmodule
